[src/afit_pkg.sv]
// ----------------------------------------------------------------------------
// afit_pkg
// Shared widths, types, status codes and the solver step table for the
// affine least-squares fit unit.
// ----------------------------------------------------------------------------
package afit_pkg;

  localparam int CoordW    = 24;
  localparam int CntW      = 13;
  localparam int SumW      = 36;
  localparam int MomW      = 60;
  localparam int ProdW     = 2 * CoordW;
  localparam int MaxPairs  = 4096;
  localparam int FracBits  = 8;
  localparam int CoefW     = 64;
  localparam int WideW     = 256;
  localparam int MulBW     = 64;
  localparam int MulCntW   = $clog2(MulBW);
  localparam int DivCntW   = $clog2(WideW);
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);
  localparam int NumCoef   = 6;
  localparam int CoefIdxW  = $clog2(NumCoef);
  localparam int MinPairs  = 3;
  localparam int Shift0    = 32 - FracBits;
  localparam int ShiftGain = 32;

  // step table layout
  localparam int PcW       = 5;
  localparam int DetStep   = 14;
  localparam int NumStart  = 15;
  localparam int NumEnd    = 23;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_SINGULAR = 2'd2
  } fit_status_t;

  // snapshot of all running sums for one set
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [SumW-1:0] sx;
    logic [SumW-1:0] sy;
    logic [SumW-1:0] su;
    logic [SumW-1:0] sv;
    logic [MomW-1:0] sxx;
    logic [MomW-1:0] syy;
    logic [MomW-1:0] sxy;
    logic [MomW-1:0] sxu;
    logic [MomW-1:0] syu;
    logic [MomW-1:0] sxv;
    logic [MomW-1:0] syv;
  } afit_sums_t;

  // queue status seen by the front
  typedef struct packed {
    logic [QCntW-1:0] used;
  } afit_q_stat_t;

  typedef enum logic [3:0] {
    A_SX, A_SY, A_SXX, A_SYY, A_SXY,
    A_CA, A_CB, A_CC, A_CE, A_CG, A_CH
  } a_sel_t;

  typedef enum logic [3:0] {
    B_CNT, B_SX, B_SY, B_SXX, B_SYY, B_SXY, B_ST, B_SXT, B_SYT
  } b_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_CA, D_CB, D_CC, D_CE, D_CG, D_CH, D_DET, D_N0, D_N1, D_N2
  } dst_t;

  typedef enum logic [1:0] {
    OP_SET, OP_ADD, OP_SUB
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t op;
    dst_t    dst;
  } ustep_t;

  // multiply-accumulate program: cofactors, determinant, then numerators
  function automatic ustep_t ucode(logic [PcW-1:0] pc);
    ustep_t s;
    unique case (pc)
      5'd0:  s = '{A_SXX, B_SYY, OP_SET, D_NONE};
      5'd1:  s = '{A_SXY, B_SXY, OP_SUB, D_CA};
      5'd2:  s = '{A_SX,  B_SYY, OP_SET, D_NONE};
      5'd3:  s = '{A_SY,  B_SXY, OP_SUB, D_CB};
      5'd4:  s = '{A_SX,  B_SXY, OP_SET, D_NONE};
      5'd5:  s = '{A_SY,  B_SXX, OP_SUB, D_CC};
      5'd6:  s = '{A_SYY, B_CNT, OP_SET, D_NONE};
      5'd7:  s = '{A_SY,  B_SY,  OP_SUB, D_CE};
      5'd8:  s = '{A_SXY, B_CNT, OP_SET, D_NONE};
      5'd9:  s = '{A_SX,  B_SY,  OP_SUB, D_CG};
      5'd10: s = '{A_SXX, B_CNT, OP_SET, D_NONE};
      5'd11: s = '{A_SX,  B_SX,  OP_SUB, D_CH};
      5'd12: s = '{A_CA,  B_CNT, OP_SET, D_NONE};
      5'd13: s = '{A_CB,  B_SX,  OP_SUB, D_NONE};
      5'd14: s = '{A_CC,  B_SY,  OP_ADD, D_DET};
      5'd15: s = '{A_CA,  B_ST,  OP_SET, D_NONE};
      5'd16: s = '{A_CB,  B_SXT, OP_SUB, D_NONE};
      5'd17: s = '{A_CC,  B_SYT, OP_ADD, D_N0};
      5'd18: s = '{A_CE,  B_SXT, OP_SET, D_NONE};
      5'd19: s = '{A_CB,  B_ST,  OP_SUB, D_NONE};
      5'd20: s = '{A_CG,  B_SYT, OP_SUB, D_N1};
      5'd21: s = '{A_CC,  B_ST,  OP_SET, D_NONE};
      5'd22: s = '{A_CG,  B_SXT, OP_SUB, D_NONE};
      5'd23: s = '{A_CH,  B_SYT, OP_ADD, D_N2};
      default: s = '{A_SX, B_SX, OP_SET, D_NONE};
    endcase
    return s;
  endfunction

  function automatic logic [WideW-1:0] wide_of_sum(logic [SumW-1:0] v);
    return {{(WideW-SumW){v[SumW-1]}}, v};
  endfunction

  function automatic logic [WideW-1:0] wide_of_mom(logic [MomW-1:0] v);
    return {{(WideW-MomW){v[MomW-1]}}, v};
  endfunction

  function automatic logic [MulBW-1:0] b_of_sum(logic [SumW-1:0] v);
    return {{(MulBW-SumW){v[SumW-1]}}, v};
  endfunction

  function automatic logic [MulBW-1:0] b_of_mom(logic [MomW-1:0] v);
    return {{(MulBW-MomW){v[MomW-1]}}, v};
  endfunction

endpackage

[src/afit_if.sv]
// ----------------------------------------------------------------------------
// afit channel interfaces
// Valid/ready channels for point pairs in and fit results out.
// ----------------------------------------------------------------------------
interface afit_in_if;
  import afit_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] src_x;
  logic [CoordW-1:0] src_y;
  logic [CoordW-1:0] dst_u;
  logic [CoordW-1:0] dst_v;
  logic              last_pair;

  modport source (output valid, src_x, src_y, dst_u, dst_v, last_pair, input ready);
  modport sink   (input valid, src_x, src_y, dst_u, dst_v, last_pair, output ready);
endinterface

interface afit_out_if;
  import afit_pkg::*;
  logic             valid;
  logic             ready;
  logic [CoefW-1:0] offset_u;
  logic [CoefW-1:0] gain_ux;
  logic [CoefW-1:0] gain_uy;
  logic [CoefW-1:0] offset_v;
  logic [CoefW-1:0] gain_vx;
  logic [CoefW-1:0] gain_vy;
  logic [1:0]       fit_status;
  logic [CntW-1:0]  pair_count;

  modport source (output valid, offset_u, gain_ux, gain_uy, offset_v, gain_vx, gain_vy,
                  fit_status, pair_count, input ready);
  modport sink   (input valid, offset_u, gain_ux, gain_uy, offset_v, gain_vx, gain_vy,
                  fit_status, pair_count, output ready);
endinterface

[src/afit_front.sv]
// ----------------------------------------------------------------------------
// afit_front
// Accepts point pairs, forms their products and keeps the running sums;
// a last pair pushes the finished set into the queue and clears the sums.
// ----------------------------------------------------------------------------
module afit_front (
  input  logic                 clk,
  input  logic                 rst_n,
  afit_in_if.sink              in_pair,
  input  afit_pkg::afit_q_stat_t q_stat,
  output logic                 q_push,
  output afit_pkg::afit_sums_t q_data
);
  import afit_pkg::*;

  logic                    a_valid_r;
  logic                    a_last_r;
  logic [CoordW-1:0]       a_x_r, a_y_r, a_u_r, a_v_r;
  logic signed [ProdW-1:0] a_xx_r, a_yy_r, a_xy_r, a_xu_r, a_yu_r, a_xv_r, a_yv_r;
  afit_sums_t              sums_r;
  afit_sums_t              upd;
  logic                    accept;
  logic                    room;
  logic [QCntW:0]          pending;

  // a last pair in flight still needs a queue slot
  assign pending = {1'b0, q_stat.used} + (QCntW+1)'(a_valid_r & a_last_r);
  assign in_pair.ready = (pending < (QCntW+1)'(QDepth));
  assign accept = in_pair.valid & in_pair.ready;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_last_r <= in_pair.last_pair;
      a_x_r    <= in_pair.src_x;
      a_y_r    <= in_pair.src_y;
      a_u_r    <= in_pair.dst_u;
      a_v_r    <= in_pair.dst_v;
      a_xx_r   <= $signed(in_pair.src_x) * $signed(in_pair.src_x);
      a_yy_r   <= $signed(in_pair.src_y) * $signed(in_pair.src_y);
      a_xy_r   <= $signed(in_pair.src_x) * $signed(in_pair.src_y);
      a_xu_r   <= $signed(in_pair.src_x) * $signed(in_pair.dst_u);
      a_yu_r   <= $signed(in_pair.src_y) * $signed(in_pair.dst_u);
      a_xv_r   <= $signed(in_pair.src_x) * $signed(in_pair.dst_v);
      a_yv_r   <= $signed(in_pair.src_y) * $signed(in_pair.dst_v);
    end
  end

  // sums with the staged pair folded in, unless the set is full
  always_comb begin
    upd = sums_r;
    if (sums_r.cnt < CntW'(MaxPairs)) begin
      upd.cnt = sums_r.cnt + CntW'(1);
      upd.sx  = sums_r.sx + {{(SumW-CoordW){a_x_r[CoordW-1]}}, a_x_r};
      upd.sy  = sums_r.sy + {{(SumW-CoordW){a_y_r[CoordW-1]}}, a_y_r};
      upd.su  = sums_r.su + {{(SumW-CoordW){a_u_r[CoordW-1]}}, a_u_r};
      upd.sv  = sums_r.sv + {{(SumW-CoordW){a_v_r[CoordW-1]}}, a_v_r};
      upd.sxx = sums_r.sxx + {{(MomW-ProdW){a_xx_r[ProdW-1]}}, a_xx_r};
      upd.syy = sums_r.syy + {{(MomW-ProdW){a_yy_r[ProdW-1]}}, a_yy_r};
      upd.sxy = sums_r.sxy + {{(MomW-ProdW){a_xy_r[ProdW-1]}}, a_xy_r};
      upd.sxu = sums_r.sxu + {{(MomW-ProdW){a_xu_r[ProdW-1]}}, a_xu_r};
      upd.syu = sums_r.syu + {{(MomW-ProdW){a_yu_r[ProdW-1]}}, a_yu_r};
      upd.sxv = sums_r.sxv + {{(MomW-ProdW){a_xv_r[ProdW-1]}}, a_xv_r};
      upd.syv = sums_r.syv + {{(MomW-ProdW){a_yv_r[ProdW-1]}}, a_yv_r};
    end
  end

  assign q_push = a_valid_r & a_last_r;
  assign q_data = upd;

  // accumulation stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else if (a_valid_r) begin
      if (a_last_r) begin
        sums_r <= '0;
      end else begin
        sums_r <= upd;
      end
    end
  end

endmodule

[src/afit_queue.sv]
// ----------------------------------------------------------------------------
// afit_queue
// Short queue of finished sum sets between the accumulator and the solver.
// ----------------------------------------------------------------------------
module afit_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  afit_pkg::afit_sums_t   push_data,
  input  logic                   pop,
  output logic                   head_valid,
  output afit_pkg::afit_sums_t   head_data,
  output afit_pkg::afit_q_stat_t stat
);
  import afit_pkg::*;

  afit_sums_t       mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] used_r;

  assign head_valid = (used_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign stat.used  = used_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      used_r <= used_r + QCntW'(push) - QCntW'(pop);
    end
  end

endmodule

[src/afit_solve.sv]
// ----------------------------------------------------------------------------
// afit_solve
// Solves the normal equations of one sum set by Cramer's rule with a
// bit-serial multiply-accumulate unit and a restoring divider.
// ----------------------------------------------------------------------------
module afit_solve (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  afit_pkg::afit_sums_t q_data,
  output logic                 q_pop,
  afit_out_if.source           out_fit
);
  import afit_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOAD   = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_STORE  = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_DPREP  = 9'b000100000,
    S_DSCALE = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  afit_sums_t         s_r;
  fit_status_t        status_r;
  logic [PcW-1:0]     pc_r;
  logic               k_r;
  logic [1:0]         j_r;
  logic [MulCntW-1:0] mbit_r;
  logic [DivCntW-1:0] dbit_r;
  logic [WideW-1:0]   acc_r, ma_r;
  logic [MulBW-1:0]   mb_r;
  logic [WideW-1:0]   ca_r, cb_r, cc_r, ce_r, cg_r, ch_r, det_r, n0_r, n1_r, n2_r;
  logic [WideW-1:0]   dabs_r, dvd_r, rem_r, quo_r;
  logic               neg_r;
  logic [CoefW-1:0]   coef_r [NumCoef];
  logic               out_valid_r;
  logic               div_done_r;
  logic [CoefIdxW-1:0] cidx_r;

  ustep_t             step;
  logic [WideW-1:0]   a_val;
  logic [MulBW-1:0]   b_val;
  logic               neg_term;
  logic [WideW-1:0]   mac_sum;
  logic [WideW-1:0]   n_sel, scaled;
  logic [WideW-1:0]   rem_sh;
  logic [WideW:0]     diff;
  logic               ge;
  logic [CoefW-1:0]   sat;
  logic               upper;
  logic [CoefW-1:0]   mag;
  logic [CoefIdxW-1:0] cidx;
  logic               fire;

  assign step  = ucode(pc_r);
  assign q_pop = (state_r == S_IDLE) && q_valid;

  // result leaves once the last coefficient is written and the slot is free
  assign fire = (state_r == S_DONE) && !div_done_r && (!out_valid_r || out_fit.ready);

  // operand selection
  always_comb begin
    unique case (step.a_sel)
      A_SX:    a_val = wide_of_sum(s_r.sx);
      A_SY:    a_val = wide_of_sum(s_r.sy);
      A_SXX:   a_val = wide_of_mom(s_r.sxx);
      A_SYY:   a_val = wide_of_mom(s_r.syy);
      A_SXY:   a_val = wide_of_mom(s_r.sxy);
      A_CA:    a_val = ca_r;
      A_CB:    a_val = cb_r;
      A_CC:    a_val = cc_r;
      A_CE:    a_val = ce_r;
      A_CG:    a_val = cg_r;
      A_CH:    a_val = ch_r;
      default: a_val = ca_r;
    endcase
    unique case (step.b_sel)
      B_CNT:   b_val = MulBW'(s_r.cnt);
      B_SX:    b_val = b_of_sum(s_r.sx);
      B_SY:    b_val = b_of_sum(s_r.sy);
      B_SXX:   b_val = b_of_mom(s_r.sxx);
      B_SYY:   b_val = b_of_mom(s_r.syy);
      B_SXY:   b_val = b_of_mom(s_r.sxy);
      B_ST:    b_val = k_r ? b_of_sum(s_r.sv) : b_of_sum(s_r.su);
      B_SXT:   b_val = k_r ? b_of_mom(s_r.sxv) : b_of_mom(s_r.sxu);
      B_SYT:   b_val = k_r ? b_of_mom(s_r.syv) : b_of_mom(s_r.syu);
      default: b_val = MulBW'(s_r.cnt);
    endcase
  end

  // one multiplier bit per cycle, top bit carries negative weight
  assign neg_term = (mbit_r == MulCntW'(MulBW - 1));
  assign mac_sum  = acc_r + (ma_r ^ {WideW{neg_term}}) + WideW'(neg_term);

  // numerator for the current coefficient, scaled to Q32.32
  always_comb begin
    unique case (j_r)
      2'd0:    n_sel = n0_r;
      2'd1:    n_sel = n1_r;
      default: n_sel = n2_r;
    endcase
    scaled = (j_r == 2'd0) ? (n_sel << Shift0) : (n_sel << ShiftGain);
  end

  // restoring division step
  assign rem_sh = {rem_r[WideW-2:0], dvd_r[WideW-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dabs_r[WideW-2:0], 1'b0};
  assign ge     = ~diff[WideW];

  // saturation of the rounded quotient
  always_comb begin
    upper = |quo_r[WideW-1:CoefW];
    mag   = quo_r[CoefW-1:0];
    if (neg_r) begin
      if (upper || (mag > {1'b1, {(CoefW-1){1'b0}}})) begin
        sat = {1'b1, {(CoefW-1){1'b0}}};
      end else begin
        sat = -mag;
      end
    end else begin
      if (upper || mag[CoefW-1]) begin
        sat = {1'b0, {(CoefW-1){1'b1}}};
      end else begin
        sat = mag;
      end
    end
  end

  assign cidx = k_r ? (CoefIdxW'(3) + CoefIdxW'(j_r)) : CoefIdxW'(j_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_data.cnt < CntW'(MinPairs)) ? S_DONE : S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_MUL;
      S_MUL: begin
        if (neg_term) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        if (pc_r == PcW'(DetStep)) begin
          state_nxt = S_CHECK;
        end else if (step.dst == D_N2) begin
          state_nxt = S_DPREP;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_CHECK:  state_nxt = (det_r == '0) ? S_DONE : S_LOAD;
      S_DPREP:  state_nxt = S_DSCALE;
      S_DSCALE: state_nxt = S_DIV;
      S_DIV: begin
        if (dbit_r == DivCntW'(WideW - 1)) begin
          if (j_r != 2'd2) begin
            state_nxt = S_DPREP;
          end else if (!k_r) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fit.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        s_r      <= q_data;
        pc_r     <= '0;
        k_r      <= 1'b0;
        j_r      <= 2'd0;
        status_r <= (q_data.cnt < CntW'(MinPairs)) ? ST_FEW : ST_OK;
      end
      S_LOAD: begin
        ma_r   <= (step.op == OP_SUB) ? -a_val : a_val;
        mb_r   <= b_val;
        mbit_r <= '0;
        if (step.op == OP_SET) begin
          acc_r <= '0;
        end
      end
      S_MUL: begin
        if (mb_r[0]) begin
          acc_r <= mac_sum;
        end
        ma_r   <= ma_r << 1;
        mb_r   <= mb_r >> 1;
        mbit_r <= mbit_r + MulCntW'(1);
      end
      S_STORE: begin
        unique case (step.dst)
          D_CA:    ca_r  <= acc_r;
          D_CB:    cb_r  <= acc_r;
          D_CC:    cc_r  <= acc_r;
          D_CE:    ce_r  <= acc_r;
          D_CG:    cg_r  <= acc_r;
          D_CH:    ch_r  <= acc_r;
          D_DET:   det_r <= acc_r;
          D_N0:    n0_r  <= acc_r;
          D_N1:    n1_r  <= acc_r;
          D_N2:    n2_r  <= acc_r;
          default: ;
        endcase
        if (step.dst != D_N2) begin
          pc_r <= pc_r + PcW'(1);
        end
      end
      S_CHECK: begin
        dabs_r <= det_r[WideW-1] ? -det_r : det_r;
        if (det_r == '0) begin
          status_r <= ST_SINGULAR;
        end
      end
      S_DPREP: begin
        neg_r <= scaled[WideW-1] ^ det_r[WideW-1];
        dvd_r <= scaled[WideW-1] ? -scaled : scaled;
      end
      S_DSCALE: begin
        // round half away from zero: (2|n| + |d|) / (2|d|)
        dvd_r  <= (dvd_r << 1) + dabs_r;
        rem_r  <= '0;
        quo_r  <= '0;
        dbit_r <= '0;
      end
      S_DIV: begin
        rem_r  <= ge ? diff[WideW-1:0] : rem_sh;
        quo_r  <= {quo_r[WideW-2:0], ge};
        dvd_r  <= dvd_r << 1;
        dbit_r <= dbit_r + DivCntW'(1);
        if (dbit_r == DivCntW'(WideW - 1)) begin
          if (j_r != 2'd2) begin
            j_r <= j_r + 2'd1;
          end else begin
            j_r  <= 2'd0;
            k_r  <= 1'b1;
            pc_r <= PcW'(NumStart);
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // coefficient write once the final quotient bit is in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= (state_r == S_DIV) && (dbit_r == DivCntW'(WideW - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV) begin
      cidx_r <= cidx;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done_r) begin
      coef_r[cidx_r] <= sat;
    end else if (state_r == S_IDLE) begin
      for (int i = 0; i < NumCoef; i++) begin
        coef_r[i] <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_fit.offset_u   <= coef_r[0];
      out_fit.gain_ux    <= coef_r[1];
      out_fit.gain_uy    <= coef_r[2];
      out_fit.offset_v   <= coef_r[3];
      out_fit.gain_vx    <= coef_r[4];
      out_fit.gain_vy    <= coef_r[5];
      out_fit.fit_status <= status_r;
      out_fit.pair_count <= s_r.cnt;
    end
  end

  assign out_fit.valid = out_valid_r;

  // too few points never yields coefficients
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fit.fit_status == ST_FEW |->
      out_fit.offset_u == '0 && out_fit.gain_ux == '0 && out_fit.gain_vy == '0)
    else $error("nonzero coefficients with too few points");

  // a singular system yields zero coefficients
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fit.fit_status == ST_SINGULAR |->
      out_fit.offset_v == '0 && out_fit.gain_uy == '0 && out_fit.gain_vx == '0)
    else $error("nonzero coefficients on singular system");

  // a solved fit always rests on at least three pairs
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fit.fit_status == ST_OK |-> out_fit.pair_count >= CntW'(MinPairs))
    else $error("fit solved with fewer than three pairs");

endmodule

[src/affine_least_squares_fit_unit.sv]
// A solved fit follows its last pair after 15 + 18 bit-serial products
// and six restoring divisions; a singular set stops after the determinant
// and a set with fewer than three pairs skips the solve. Throughput: one
// pair per cycle while the queue has room; a set's solve is bound by the
// multiply-accumulate unit and the restoring divider, with two sets queued.
// Reset (rst_n, synchronous): sums, count, queue and result valid cleared.
// ----------------------------------------------------------------------------
// affine_least_squares_fit_unit
// Least-squares affine fit of point pairs: accumulator front, sum-set
// queue and normal-equation solver.
// ----------------------------------------------------------------------------
module affine_least_squares_fit_unit (
  input  logic       clk,
  input  logic       rst_n,
  afit_in_if.sink    in_pair,
  afit_out_if.source out_fit
);
  import afit_pkg::*;

  logic         q_push, q_pop, q_valid;
  afit_sums_t   q_in, q_head;
  afit_q_stat_t q_stat;

  // accumulation of pairs
  afit_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pair (in_pair),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  // finished sum sets
  afit_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .stat       (q_stat)
  );

  // solver
  afit_solve u_solve (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .out_fit (out_fit)
  );

endmodule
